@@ rtl/bloom_filter_probe_top_defines.svh @@
// Assertion helpers for the bloom filter probe checker.
`ifndef BLOOM_FILTER_PROBE_TOP_DEFINES_SVH
`define BLOOM_FILTER_PROBE_TOP_DEFINES_SVH

// Same-cycle implication.
`define BFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bloom filter probe check failed");

// Next-cycle implication.
`define BFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bloom filter probe check failed");

`endif

@@ rtl/bfp_pkg.sv @@
package bfp_pkg;

    localparam int BYTE_INDEX_W = 13;
    localparam int BYTE_W       = 8;
    localparam int FP_W         = 64;
    localparam int POS_W        = 16;   // bit_mask width bounds every probe position
    localparam int HASH_W       = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MASK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES = 2'd2;

    localparam logic [HASH_W-1:0] MAX_HASHES = 6'd32;

    typedef struct packed {
        logic [POS_W-1:0]  bit_mask;
        logic              present;
        logic [HASH_W-1:0] num_hashes;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic might_contain;
    } t_res;

endpackage

@@ rtl/bfp_item_if.sv @@
interface bfp_item_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic [bfp_pkg::BYTE_INDEX_W-1:0]  byte_index;
    logic [bfp_pkg::BYTE_W-1:0]        byte_value;
    logic [bfp_pkg::FP_W-1:0]          fingerprint;

    modport source (output valid, op, byte_index, byte_value, fingerprint, input ready);
    modport sink   (input valid, op, byte_index, byte_value, fingerprint, output ready);
endinterface

@@ rtl/bfp_res_if.sv @@
interface bfp_res_if;
    logic valid;
    logic ready;
    logic might_contain;

    modport source (output valid, might_contain, input ready);
    modport sink   (input valid, might_contain, output ready);
endinterface

@@ rtl/bfp_cfg_if.sv @@
interface bfp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bfp_pkg::CFG_IDX_W-1:0]    index;
    logic [bfp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/bfp_engine.sv @@
module bfp_engine #(
    parameter int INDEX_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bfp_pkg::t_cfg i_cfg,
    bfp_item_if.sink      item,
    input  logic          i_out_free,
    output bfp_pkg::t_res o_res
);

    localparam int AW    = (INDEX_BITS > 3) ? INDEX_BITS - 3 : 1;
    localparam int DEPTH = 1 << (INDEX_BITS - 3);
    localparam int PW    = (INDEX_BITS < bfp_pkg::POS_W) ? INDEX_BITS : bfp_pkg::POS_W;
    localparam logic [AW-1:0] ADDR_MASK = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROBE = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [bfp_pkg::POS_W-1:0]  r_acc, n_acc;
    logic [bfp_pkg::POS_W-1:0]  r_h2, n_h2;
    logic [bfp_pkg::HASH_W-1:0] r_left, n_left;
    logic [2:0]                 r_sel, n_sel;
    logic                       r_mc, n_mc;
    logic [bfp_pkg::BYTE_W-1:0] r_rd;

    logic [bfp_pkg::BYTE_W-1:0] mem [DEPTH];

    logic                       accept;
    logic                       is_query;
    logic [bfp_pkg::HASH_W-1:0] probes;
    logic [bfp_pkg::POS_W-1:0]  h1_lo;
    logic [bfp_pkg::POS_W-1:0]  h2_lo;
    logic [bfp_pkg::POS_W-1:0]  src;
    logic [PW-1:0]              pos;
    logic [PW-1:0]              pos_byte;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic                       wr_en;
    logic                       hit;

    assign item.ready = (r_state == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign is_query   = (item.op == bfp_pkg::OP_QUERY);
    assign probes     = (i_cfg.num_hashes > bfp_pkg::MAX_HASHES) ? bfp_pkg::MAX_HASHES
                                                                 : i_cfg.num_hashes;

    // Only the low position bits survive the mask, so the sum runs narrow.
    assign h1_lo = item.fingerprint[bfp_pkg::POS_W-1:0];
    assign h2_lo = item.fingerprint[32 +: bfp_pkg::POS_W] | bfp_pkg::POS_W'(1);

    // First probe is addressed straight from the input item.
    assign src      = (r_state == S_IDLE) ? h1_lo : r_acc;
    assign pos      = src[PW-1:0] & i_cfg.bit_mask[PW-1:0];
    assign pos_byte = pos >> 3;
    assign rd_addr  = AW'(pos_byte) & ADDR_MASK;
    assign wr_addr  = AW'(item.byte_index) & ADDR_MASK;
    assign wr_en    = accept && !is_query;
    assign hit      = r_rd[r_sel];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= item.byte_value;
        end
        r_rd <= mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_h2    = r_h2;
        n_left  = r_left;
        n_sel   = r_sel;
        n_mc    = r_mc;
        unique case (r_state)
            S_IDLE: begin
                if (accept && is_query) begin
                    if (!i_cfg.present || probes == '0) begin
                        n_mc    = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_acc   = h1_lo + h2_lo;
                        n_h2    = h2_lo;
                        n_left  = probes;
                        n_sel   = pos[2:0];
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (!hit) begin
                    n_mc    = 1'b0;
                    n_state = S_DONE;
                end else if (r_left == bfp_pkg::HASH_W'(1)) begin
                    n_mc    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_left = r_left - bfp_pkg::HASH_W'(1);
                    n_sel  = pos[2:0];
                    n_acc  = r_acc + r_h2;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_acc  <= n_acc;
        r_h2   <= n_h2;
        r_left <= n_left;
        r_sel  <= n_sel;
        r_mc   <= n_mc;
    end

    assign o_res.valid         = (r_state == S_DONE) && i_out_free;
    assign o_res.might_contain = r_mc;

endmodule

@@ rtl/bloom_filter_probe_top.sv @@
// channel   dir  handshake      payload
// i_item    in   valid/ready    op, byte_index, byte_value, fingerprint
// o_res     out  valid/ready    might_contain (one per query, none per write)
// i_cfg     in   valid/ready    index, data (always ready)
//
// A write item is stored in the filter RAM. A query makes k probes, k being up
// to num_hashes (at most 32), fewer on the first clear bit, none with no filter
// or zero hashes: the filter RAM has one read port and gives one probe per cycle.
// Reset clears control and config; filter RAM contents stay undefined until
// written. A stalled result holds in the output register; no new item is
// taken until the pending result has moved there.
module bloom_filter_probe_top #(
    parameter int INDEX_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bfp_item_if.sink  i_item,
    bfp_res_if.source o_res,
    bfp_cfg_if.sink   i_cfg
);

    bfp_pkg::t_cfg r_cfg;
    bfp_pkg::t_res eng_res;
    logic          r_out_valid;
    logic          r_out_mc;
    logic          out_free;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bfp_pkg::CFG_BIT_MASK:   r_cfg.bit_mask   <= i_cfg.data;
                bfp_pkg::CFG_PRESENT:    r_cfg.present    <= i_cfg.data[0];
                bfp_pkg::CFG_NUM_HASHES: r_cfg.num_hashes <= i_cfg.data[bfp_pkg::HASH_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || o_res.ready;

    bfp_engine #(
        .INDEX_BITS (INDEX_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .item       (i_item),
        .i_out_free (out_free),
        .o_res      (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (eng_res.valid) begin
            r_out_mc <= eng_res.might_contain;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.might_contain = r_out_mc;

endmodule

@@ rtl/bfp_checker.sv @@
`include "bloom_filter_probe_top_defines.svh"

module bfp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_op,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_mc
);

    logic in_acc;
    logic out_stall;

    assign in_acc    = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    // a stalled result holds its value
    `BFP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(i_out_mc))

    // a query keeps the input closed for at least the next cycle
    `BFP_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, in_acc && i_in_op == bfp_pkg::OP_QUERY,
        !i_in_ready)

    // no result shows up in the cycle right after an item is taken
    `BFP_ASSERT_NEXT(a_no_early_res, i_clk, i_rst_n, in_acc, !$rose(i_out_valid))

    // a write taken while no result is pending raises no result
    `BFP_ASSERT_NOW(a_write_silent, i_clk, i_rst_n,
        in_acc && i_in_op == bfp_pkg::OP_WRITE && !i_out_valid, ##1 !i_out_valid)

endmodule

bind bloom_filter_probe_top bfp_checker u_bfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_op     (i_item.op),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_mc    (o_res.might_contain)
);
